>>> hdl/bvhms_pkg.sv
`timescale 1ns / 1ps
package bvhms_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_W = 16;
  localparam int THR_W   = 26;
  localparam int STEP_W  = 5;
  localparam int AXIS_W  = 2;
  localparam int IMB_W   = 8;

  localparam logic [IMB_W-1:0] NO_PLANE = 8'd255;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  // one stored box: lower and upper corners
  typedef struct packed {
    vec3_t lo;
    vec3_t hi;
  } box_t;

  // pick one axis out of a corner vector
  function automatic logic signed [COORD_W-1:0] sel_coord(input vec3_t v,
                                                          input logic [AXIS_W-1:0] a);
    logic signed [COORD_W-1:0] r;
    case (a)
      AXIS_X:  r = $signed(v[0]);
      AXIS_Y:  r = $signed(v[1]);
      AXIS_Z:  r = $signed(v[2]);
      default: r = $signed(v[2]);
    endcase
    return r;
  endfunction

endpackage

>>> hdl/bvhms_box_store.sv
`timescale 1ns / 1ps
module bvhms_box_store
  import bvhms_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  box_t             wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output box_t             rd_data
);

  box_t mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/bvhms_plane_test.sv
`timescale 1ns / 1ps
module bvhms_plane_test
  import bvhms_pkg::*;
#(
  parameter int PLANES = 20
) (
  input  box_t                     box,
  input  logic [AXIS_W-1:0]        axis,
  input  logic signed [THR_W-1:0]  thr,
  output logic                     below
);

  localparam logic signed [THR_W-1:0] P_S = THR_W'(PLANES + 1);

  logic signed [THR_W-1:0] lo_e;
  logic signed [THR_W-1:0] hi_e;
  logic signed [THR_W-1:0] cen;

  // scaled centroid against the plane threshold
  always_comb begin
    lo_e  = THR_W'(sel_coord(box.lo, axis));
    hi_e  = THR_W'(sel_coord(box.hi, axis));
    cen   = (lo_e + hi_e) * P_S;
    below = (cen < thr);
  end

endmodule

>>> hdl/bvh_midpoint_split_selector_unit.sv
`timescale 1ns / 1ps
// boxes load one per cycle while busy is low; a final request starts the split, which keeps
//   busy high while the n boxes are scanned through the shared plane test for each trial plane;
//   results stream one per cycle, the last one in the cycle in which busy drops
// an error set gives its single result in the cycle after the final request
// throughput: busy is high during the split; the receiver cannot stall results
// reset: synchronous active-high rst clears the sequencer and set state; store unset
module bvh_midpoint_split_selector_unit
  import bvhms_pkg::*;
#(
  parameter int MAX_BOXES    = 64,
  parameter int TRIAL_PLANES = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] min_x,
  input  logic signed [COORD_W-1:0] min_y,
  input  logic signed [COORD_W-1:0] min_z,
  input  logic signed [COORD_W-1:0] max_x,
  input  logic signed [COORD_W-1:0] max_y,
  input  logic signed [COORD_W-1:0] max_z,
  input  logic                      final_box,
  output logic                      strobe,
  output logic [5:0]                box_number,
  output logic                      goes_left,
  output logic [1:0]                split_axis,
  output logic [4:0]                split_step,
  output logic                      run_end,
  output logic                      set_error
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic signed [THR_W-1:0] P_S = THR_W'(TRIAL_PLANES + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TRIAL_PLANES);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BOXES);
  localparam logic [CNT_W-1:0]  TWO       = CNT_W'(2);

  typedef enum logic [3:0] {
    S_IDLE, S_AX_INIT, S_SCAN, S_WAIT, S_EVAL, S_PICK, S_SEL1, S_SEL2, S_REB
  } state_t;

  typedef enum logic [1:0] {PH_SEARCH, PH_COUNT, PH_EMIT} phase_t;

  state_t state;
  phase_t phase;

  // set state
  logic [CNT_W-1:0] loaded_count;
  logic             overflow_seen;
  vec3_t            enc_lo;
  vec3_t            enc_hi;

  // run state
  logic [CNT_W-1:0]        n;
  vec3_t                   gmin;
  vec3_t                   gmax;
  logic [AXIS_W-1:0]       axis;
  logic [STEP_W-1:0]       k;
  logic signed [THR_W-1:0] thr;
  logic [IDX_W-1:0]        idx;
  logic [CNT_W-1:0]        lcnt;
  logic [CNT_W-1:0]        part_l;
  logic [CNT_W-1:0]        lb;
  logic [CNT_W-1:0]        rb;
  logic [CNT_W-1:0]        m1;
  logic [CNT_W-1:0]        m2;
  logic [IMB_W-1:0]        best_imb [3];
  logic [STEP_W-1:0]       best_step [3];

  // read pipeline
  logic             v1;
  logic [IDX_W-1:0] idx_d;

  box_t in_box;
  box_t rd_box;
  logic below;
  logic st_wr;
  vec3_t enc_lo_new;
  vec3_t enc_hi_new;

  logic signed [THR_W-1:0] gmin_e;
  logic signed [THR_W-1:0] ext;
  logic signed [THR_W-1:0] base2;
  logic signed [THR_W-1:0] kext;
  logic [CNT_W-1:0]        r_cnt;
  logic [CNT_W-1:0]        d_cnt;
  logic [CNT_W-1:0]        m1_c;
  logic [CNT_W-1:0]        m2_c;
  logic [CNT_W-1:0]        l1_c;
  logic [CNT_W-1:0]        r1_c;
  logic                    x_win;
  logic                    y_win;
  logic                    emit_left;
  logic [CNT_W-1:0]        n_in;
  logic                    emit_now;
  logic                    err_now;

  assign busy  = (state != S_IDLE);
  assign in_box.lo = vec3_t'({min_z, min_y, min_x});
  assign in_box.hi = vec3_t'({max_z, max_y, max_x});
  assign st_wr = start && !busy && (loaded_count < MAX_CNT);
  assign n_in  = loaded_count + CNT_W'(1);

  // result strobe sources
  assign emit_now = v1 && (phase == PH_EMIT);
  assign err_now  = start && !busy && final_box &&
                    (overflow_seen || !st_wr || (loaded_count == '0));

  // enclosing box including the incoming box
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      enc_lo_new[a] = ($signed(in_box.lo[a]) < $signed(enc_lo[a])) ? in_box.lo[a] : enc_lo[a];
      enc_hi_new[a] = ($signed(in_box.hi[a]) > $signed(enc_hi[a])) ? in_box.hi[a] : enc_hi[a];
    end
  end

  bvhms_box_store #(.DEPTH(MAX_BOXES), .IDX_W(IDX_W)) u_store (
    .clk     (clk),
    .wr_en   (st_wr),
    .wr_addr (loaded_count[IDX_W-1:0]),
    .wr_data (in_box),
    .rd_addr (idx),
    .rd_data (rd_box)
  );

  bvhms_plane_test #(.PLANES(TRIAL_PLANES)) u_test (
    .box   (rd_box),
    .axis  (axis),
    .thr   (thr),
    .below (below)
  );

  // threshold terms for the current axis
  always_comb begin
    gmin_e = THR_W'(sel_coord(gmin, axis));
    ext    = THR_W'(sel_coord(gmax, axis)) - gmin_e;
    base2  = (P_S * gmin_e) <<< 1;
    kext   = ($signed(THR_W'(best_step[axis])) * ext) <<< 1;
  end

  // imbalance of the plane just scanned
  always_comb begin
    r_cnt = n - lcnt;
    d_cnt = (lcnt > r_cnt) ? (lcnt - r_cnt) : (r_cnt - lcnt);
  end

  // rebalancing moves
  always_comb begin
    m1_c = '0;
    if (part_l < TWO) begin
      m1_c = ((TWO - part_l) < (n - part_l)) ? (TWO - part_l) : (n - part_l);
    end
    l1_c = part_l + m1_c;
    r1_c = n - l1_c;
    m2_c = '0;
    if (r1_c < TWO) begin
      m2_c = ((TWO - r1_c) < l1_c) ? (TWO - r1_c) : l1_c;
    end
  end

  // axis choice
  always_comb begin
    x_win = (best_imb[0] != NO_PLANE) && (best_imb[0] <= best_imb[1]) &&
            (best_imb[0] <= best_imb[2]);
    y_win = (best_imb[1] != NO_PLANE) && (best_imb[1] <= best_imb[0]) &&
            (best_imb[1] <= best_imb[2]);
  end

  // final side of the box in the compare stage
  always_comb begin
    if (below) begin
      emit_left = (lb >= m2);
    end else if (rb < m1) begin
      emit_left = ((part_l + rb) >= m2);
    end else begin
      emit_left = 1'b0;
    end
  end

  // sequencer, set state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_SEARCH;
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        enc_lo[a]    <= COORD_MAX;
        enc_hi[a]    <= COORD_MIN;
        best_imb[a]  <= NO_PLANE;
        best_step[a] <= STEP_W'(1);
      end
      v1         <= 1'b0;
      strobe     <= 1'b0;
      set_error  <= 1'b0;
      run_end    <= 1'b0;
      box_number <= '0;
      goes_left  <= 1'b0;
      split_axis <= '0;
      split_step <= '0;
    end else begin
      strobe <= emit_now || err_now;
      v1     <= (state == S_SCAN);
      idx_d  <= idx;

      // compare stage
      if (v1) begin
        if (phase == PH_EMIT) begin
          set_error  <= 1'b0;
          box_number <= 6'(idx_d);
          goes_left  <= emit_left;
          split_axis <= axis;
          split_step <= best_step[axis];
          run_end    <= (CNT_W'(idx_d) == n - CNT_W'(1));
          if (below) lb <= lb + CNT_W'(1);
          else       rb <= rb + CNT_W'(1);
        end else if (below) begin
          lcnt <= lcnt + CNT_W'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            if (final_box) begin
              loaded_count  <= '0;
              overflow_seen <= 1'b0;
              for (int a = 0; a < 3; a++) begin
                enc_lo[a] <= COORD_MAX;
                enc_hi[a] <= COORD_MIN;
              end
              if (err_now) begin
                set_error  <= 1'b1;
                run_end    <= 1'b1;
                box_number <= '0;
                goes_left  <= 1'b0;
                split_axis <= '0;
                split_step <= '0;
              end else begin
                n     <= n_in;
                gmin  <= enc_lo_new;
                gmax  <= enc_hi_new;
                axis  <= AXIS_X;
                phase <= PH_SEARCH;
                state <= S_AX_INIT;
              end
            end else if (st_wr) begin
              loaded_count <= n_in;
              enc_lo       <= enc_lo_new;
              enc_hi       <= enc_hi_new;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        S_AX_INIT: begin
          thr             <= base2 + (ext <<< 1);
          k               <= STEP_W'(1);
          best_imb[axis]  <= NO_PLANE;
          best_step[axis] <= STEP_W'(1);
          idx             <= '0;
          lcnt            <= '0;
          state           <= S_SCAN;
        end
        S_SCAN: begin
          if (CNT_W'(idx) == n - CNT_W'(1)) begin
            state <= S_WAIT;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_WAIT: begin
          case (phase)
            PH_SEARCH: state <= S_EVAL;
            PH_COUNT:  state <= S_REB;
            default:   state <= S_IDLE;
          endcase
        end
        S_EVAL: begin
          if ((lcnt != '0) && (r_cnt != '0) && (IMB_W'(d_cnt) < best_imb[axis])) begin
            best_imb[axis]  <= IMB_W'(d_cnt);
            best_step[axis] <= k;
          end
          idx  <= '0;
          lcnt <= '0;
          if (k == LAST_STEP) begin
            if (axis == AXIS_Z) begin
              state <= S_PICK;
            end else begin
              axis  <= axis + AXIS_W'(1);
              state <= S_AX_INIT;
            end
          end else begin
            k     <= k + STEP_W'(1);
            thr   <= thr + (ext <<< 1);
            state <= S_SCAN;
          end
        end
        S_PICK: begin
          if (x_win)      axis <= AXIS_X;
          else if (y_win) axis <= AXIS_Y;
          else            axis <= AXIS_Z;
          state <= S_SEL1;
        end
        S_SEL1: begin
          thr   <= base2;
          state <= S_SEL2;
        end
        S_SEL2: begin
          thr   <= thr + kext;
          idx   <= '0;
          lcnt  <= '0;
          // rebalancing counts once the partition count is known
          if (phase == PH_EMIT) begin
            m1 <= m1_c;
            m2 <= m2_c;
            lb <= '0;
            rb <= '0;
          end else begin
            phase <= PH_COUNT;
          end
          state <= S_SCAN;
        end
        S_REB: begin
          part_l <= lcnt;
          m1     <= '0;
          m2     <= '0;
          state  <= S_SEL1;
          phase  <= PH_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // error results always close the run
  a_err_end : assert property (@(posedge clk) disable iff (rst)
    strobe && set_error |-> run_end)
    else $error("error result without run end");

  // split results name a legal plane
  a_step_ok : assert property (@(posedge clk) disable iff (rst)
    strobe && !set_error |-> (split_step >= 5'd1) && (split_step <= 5'(TRIAL_PLANES)))
    else $error("split step out of range");

  // last split result is the last stored box
  a_last_box : assert property (@(posedge clk) disable iff (rst)
    strobe && !set_error && run_end |-> (box_number == 6'(n - CNT_W'(1))))
    else $error("run end on wrong box");

  // no compare work while idle and accepting
  a_idle_quiet : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && (phase != PH_EMIT) |-> !v1)
    else $error("compare stage active while idle");

endmodule
